@@ hw/rtl/lgdd_pkg.sv @@
`timescale 1ns / 1ps

package lgdd_pkg;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_ALLOCATE = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_DETECT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_EDGE_DONE = 2'd0,
    KIND_NO_CYCLE  = 2'd1,
    KIND_MEMBER    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MARK_WHITE = 2'd0,
    MARK_GREY  = 2'd1,
    MARK_BLACK = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SEARCH,
    ST_WALK
  } state_e;

  localparam int unsigned NumberW = 5;

endpackage

@@ hw/rtl/lgdd_ffs.sv @@
`timescale 1ns / 1ps

// Find the lowest set bit of a vector.
module lgdd_ffs #(
  parameter int unsigned WIDTH = 30
) (
  input  logic [WIDTH-1:0]         vec_i,
  output logic                     found_o,
  output logic [$clog2(WIDTH)-1:0] idx_o
);

  localparam int unsigned IW = $clog2(WIDTH);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

@@ hw/rtl/lock_graph_deadlock_detector.sv @@
`timescale 1ns / 1ps

// Deadlock detector over a resource allocation graph of LOCK_NODES locks and
// THREAD_NODES threads (node numbers: locks first, then threads).
// Input channel (in_valid_i/in_ready_o) takes an operation: request, allocate,
// release or detect. Output channel (out_valid_o/out_ready_i) returns results;
// last_o marks the final result of an item.
// Edge operations answer with one edge-done result.
// Detect clears the search marks, then runs a depth-first search with one
// find-first-set unit over the current node's adjacency row; each search
// step descends, closes a cycle, retires a node, or, with the stack empty,
// moves on to the next root. A found cycle ends the search early.
// A found cycle is reported member by member, starting with the node whose
// edge closed it and ending with the node it reached; otherwise a single
// no-deadlock result is given.
// Input is taken only between items. A stalled receiver holds the output
// register and freezes the search walk. Reset empties the graph.
module lock_graph_deadlock_detector #(
  parameter int unsigned LOCK_NODES   = 10,
  parameter int unsigned THREAD_NODES = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [4:0] thread_id_i,
  input  logic [3:0] lock_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic       node_is_thread_o,
  output logic [4:0] node_number_o,
  output logic       last_o
);

  localparam int unsigned N  = LOCK_NODES + THREAD_NODES;
  localparam int unsigned NW = $clog2(N);
  localparam int unsigned DW = $clog2(N + 1);

  lgdd_pkg::state_e state_q, state_d;

  logic [N-1:0]        rows_q [N];
  lgdd_pkg::mark_e     mark_q [N];
  logic [NW-1:0]       came_q [N];
  logic [DW-1:0]       next_q [N];
  logic [NW-1:0]       stack_q [N];
  logic [DW-1:0]       depth_q;
  logic [DW-1:0]       root_q;
  logic [NW-1:0]       target_q;
  logic [NW-1:0]       walk_q;
  logic [DW-1:0]       cnt_q;

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic        thr_q;
  logic [4:0]  num_q;
  logic        last_q;

  logic in_acc, out_free, is_detect, ids_ok;
  logic [6:0] t_sum;
  logic [NW-1:0] t_idx, l_idx, root_idx, top_pos, top_idx, hit_idx, par;
  logic [N-1:0] cand;
  logic hit;
  logic root_end, root_white;
  logic emit;
  lgdd_pkg::kind_e e_kind;
  logic e_thr, e_last, walk_last;
  logic [4:0] e_num;
  logic [6:0] thr_num;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lgdd_pkg::ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_detect  = operation_i == lgdd_pkg::OP_DETECT;
  assign ids_ok     = ({1'b0, thread_id_i} < 6'(THREAD_NODES))
                   && ({2'b0, lock_id_i} < 6'(LOCK_NODES));
  assign t_sum      = 7'(LOCK_NODES) + 7'(thread_id_i);
  assign t_idx      = NW'(t_sum);
  assign l_idx      = NW'(lock_id_i);

  assign root_idx   = root_q[NW-1:0];
  assign root_end   = root_q == DW'(N);
  assign root_white = mark_q[root_idx] == lgdd_pkg::MARK_WHITE;
  // node on top of the search stack
  assign top_pos    = NW'(depth_q - 1'b1);
  assign top_idx    = stack_q[top_pos];

  // candidates: out-edges of the top node from its resume point, not finished
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cand[i] = rows_q[top_idx][i] && (mark_q[i] != lgdd_pkg::MARK_BLACK)
             && (i >= int'(next_q[top_idx]));
    end
  end

  lgdd_ffs #(.WIDTH(N)) u_ffs (
    .vec_i  (cand),
    .found_o(hit),
    .idx_o  (hit_idx)
  );

  assign par       = came_q[walk_q];
  assign walk_last = (par == target_q) || (cnt_q == DW'(N - 1));
  assign thr_num   = 7'(par) - 7'(LOCK_NODES);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgdd_pkg::ST_IDLE: begin
        if (in_acc && is_detect) state_d = lgdd_pkg::ST_ROOT;
      end
      lgdd_pkg::ST_ROOT: begin
        if (root_end) begin
          if (out_free) state_d = lgdd_pkg::ST_IDLE;
        end else if (root_white) begin
          state_d = lgdd_pkg::ST_SEARCH;
        end
      end
      lgdd_pkg::ST_SEARCH: begin
        if (depth_q == '0) begin
          state_d = lgdd_pkg::ST_ROOT;
        end else if (hit && mark_q[hit_idx] == lgdd_pkg::MARK_GREY) begin
          state_d = lgdd_pkg::ST_WALK;
        end
      end
      lgdd_pkg::ST_WALK: begin
        if (out_free && walk_last) state_d = lgdd_pkg::ST_IDLE;
      end
      default: state_d = lgdd_pkg::ST_IDLE;
    endcase
  end

  // result emission
  always_comb begin
    emit   = 1'b0;
    e_kind = lgdd_pkg::KIND_EDGE_DONE;
    e_thr  = 1'b0;
    e_num  = '0;
    e_last = 1'b1;
    unique case (state_q)
      lgdd_pkg::ST_IDLE: begin
        emit = in_acc && !is_detect;
      end
      lgdd_pkg::ST_ROOT: begin
        emit   = root_end && out_free;
        e_kind = lgdd_pkg::KIND_NO_CYCLE;
      end
      lgdd_pkg::ST_WALK: begin
        emit   = out_free;
        e_kind = lgdd_pkg::KIND_MEMBER;
        e_last = walk_last;
        if (int'(par) >= LOCK_NODES) begin
          e_thr = 1'b1;
          e_num = thr_num[4:0];
        end else begin
          e_num = 5'(par);
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgdd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      depth_q     <= '0;
      root_q      <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < N; i++) begin
        rows_q[i] <= '0;
        mark_q[i] <= lgdd_pkg::MARK_WHITE;
        came_q[i] <= '0;
        next_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (in_acc && !is_detect && ids_ok) begin
        unique case (operation_i)
          lgdd_pkg::OP_REQUEST: rows_q[t_idx][l_idx] <= 1'b1;
          lgdd_pkg::OP_ALLOCATE: begin
            rows_q[l_idx][t_idx] <= 1'b1;
            rows_q[t_idx][l_idx] <= 1'b0;
          end
          default: rows_q[l_idx][t_idx] <= 1'b0;
        endcase
      end

      if (in_acc && is_detect) begin
        root_q  <= '0;
        depth_q <= '0;
        for (int i = 0; i < N; i++) begin
          mark_q[i] <= lgdd_pkg::MARK_WHITE;
          came_q[i] <= '0;
          next_q[i] <= '0;
        end
      end

      if (state_q == lgdd_pkg::ST_ROOT && !root_end) begin
        if (root_white) begin
          mark_q[root_idx] <= lgdd_pkg::MARK_GREY;
          next_q[root_idx] <= '0;
          depth_q          <= DW'(1);
        end else begin
          root_q <= root_q + 1'b1;
        end
      end

      if (state_q == lgdd_pkg::ST_SEARCH) begin
        if (depth_q == '0) begin
          root_q <= root_q + 1'b1;
        end else if (!hit) begin
          mark_q[top_idx] <= lgdd_pkg::MARK_BLACK;
          depth_q         <= depth_q - 1'b1;
        end else begin
          came_q[hit_idx] <= top_idx;
          if (mark_q[hit_idx] == lgdd_pkg::MARK_WHITE) begin
            next_q[top_idx] <= DW'(hit_idx) + 1'b1;
            mark_q[hit_idx] <= lgdd_pkg::MARK_GREY;
            next_q[hit_idx] <= '0;
            if (depth_q < DW'(N)) depth_q <= depth_q + 1'b1;
          end else begin
            cnt_q <= '0;
          end
        end
      end

      if (state_q == lgdd_pkg::ST_WALK && out_free) cnt_q <= cnt_q + 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == lgdd_pkg::ST_ROOT && !root_end && root_white) begin
      stack_q[0] <= root_idx;
    end
    if (state_q == lgdd_pkg::ST_SEARCH && depth_q != '0 && hit) begin
      if (mark_q[hit_idx] == lgdd_pkg::MARK_WHITE) begin
        if (depth_q < DW'(N)) stack_q[NW'(depth_q)] <= hit_idx;
      end else begin
        target_q <= hit_idx;
        walk_q   <= hit_idx;
      end
    end
    if (state_q == lgdd_pkg::ST_WALK && out_free) walk_q <= par;
    if (emit) begin
      kind_q <= e_kind;
      thr_q  <= e_thr;
      num_q  <= e_num;
      last_q <= e_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign node_is_thread_o = thr_q;
  assign node_number_o    = num_q;
  assign last_o           = last_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(N))
    else $error("search stack overflow");

  a_top_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgdd_pkg::ST_SEARCH && depth_q != '0)
      |-> mark_q[top_idx] == lgdd_pkg::MARK_GREY)
    else $error("top of stack is not grey");

  a_detect_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_detect) |=> state_q == lgdd_pkg::ST_ROOT)
    else $error("detect did not start search");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lgdd_pkg::ST_WALK |-> cnt_q < DW'(N))
    else $error("cycle walk ran too long");

endmodule
